// ===== src/uer_pkg.sv =====
`default_nettype none
package uer_pkg;

    // Width of the echo width counter and of the quotient built by the divider
    localparam int COUNT_BITS = 16;

    localparam int CFG_W   = 16;
    localparam int DIV_W   = 16;
    localparam int DIST_W  = 8;
    localparam int CMD_W   = 2;
    localparam int IDX_W   = 1;
    localparam int STEP_W  = $clog2(COUNT_BITS + 1);

    localparam logic [DIST_W-1:0]     DIST_MAX  = 8'd255;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
    localparam logic [CFG_W-1:0]      TRIG_MAX  = {CFG_W{1'b1}};

    localparam logic [CFG_W-1:0] TICKS_PER_CM_RESET  = 16'd58;
    localparam logic [CFG_W-1:0] TRIGGER_TICKS_RESET = 16'd10;

    // Configuration register indexes
    localparam logic [IDX_W-1:0] CFG_TICKS_PER_CM  = 1'd0;
    localparam logic [IDX_W-1:0] CFG_TRIGGER_TICKS = 1'd1;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_NONE  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_START = 2'd1;
    localparam logic [CMD_W-1:0] CMD_TAKE  = 2'd2;

endpackage
`default_nettype wire

// ===== src/uer_div.sv =====
`default_nettype none
module uer_div (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           start,
    input  wire logic [uer_pkg::COUNT_BITS-1:0] dividend,
    input  wire logic [uer_pkg::DIV_W-1:0]      divisor,
    output logic                                busy,
    output logic [uer_pkg::DIST_W-1:0]          quotient
);
    import uer_pkg::*;

    logic [DIV_W-1:0]      rem_reg, rem_next;
    logic [COUNT_BITS-1:0] quo_reg, quo_next;
    logic [DIV_W-1:0]      div_reg, div_next;
    logic [STEP_W-1:0]     step_reg, step_next;
    logic                  busy_reg, busy_next;

    logic [DIV_W:0] trial;
    logic [DIV_W:0] diff;

    // One restoring step: shift in the next dividend bit, subtract if it fits
    always_comb begin
        trial     = {rem_reg, quo_reg[COUNT_BITS-1]};
        diff      = trial - {1'b0, div_reg};
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        div_next  = div_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        if (start) begin
            rem_next  = '0;
            quo_next  = dividend;
            div_next  = divisor;
            step_next = STEP_W'(COUNT_BITS);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (!diff[DIV_W]) begin
                rem_next = diff[DIV_W-1:0];
                quo_next = {quo_reg[COUNT_BITS-2:0], 1'b1};
            end else begin
                rem_next = trial[DIV_W-1:0];
                quo_next = {quo_reg[COUNT_BITS-2:0], 1'b0};
            end
            step_next = step_reg - STEP_W'(1);
            if (step_reg == STEP_W'(1)) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            step_reg <= step_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        div_reg <= div_next;
    end

    // Clamp the quotient to the distance range
    assign quotient = (quo_reg > COUNT_BITS'(DIST_MAX)) ? DIST_MAX : quo_reg[DIST_W-1:0];
    assign busy     = busy_reg;

endmodule
`default_nettype wire

// ===== src/ultrasonic_echo_ranger.sv =====
`default_nettype none
// Ultrasonic echo ranger for HC-SR04 style sensors. Each input word is one timer
// tick carrying a command (plain, start, take) and the sampled echo level; each
// accepted tick yields exactly one result word showing the trigger level for that
// tick, busy and ready flags, and on a take of a finished measurement the
// distance in centimetres (echo width in ticks divided by ticks_per_cm, clamped
// to 255; a zero divisor gives 255). A start from idle raises the trigger for
// trigger_ticks ticks (one if zero), then waits for a rising echo edge and counts
// high ticks (clamped at 2^COUNT_BITS-1) until the falling edge. Rate: one tick
// per clock cycle while the divider is idle and no result word is stalled; a
// result word waits in an output register while the next tick is taken. The tick
// that sees the falling edge starts the restoring divider, which retires one
// quotient bit per cycle; s_ready stays low until it is done. Configuration
// writes on the cfg channel are always ready and are meant for idle periods only.
module ultrasonic_echo_ranger (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    // tick input
    input  wire logic                         s_valid,
    output logic                              s_ready,
    input  wire logic [uer_pkg::CMD_W-1:0]    s_command,
    input  wire logic                         s_echo,
    // result output
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output logic                              m_trigger_out,
    output logic                              m_busy_res,
    output logic                              m_ready_res,
    output logic                              m_result_valid,
    output logic [uer_pkg::DIST_W-1:0]        m_distance_cm,
    // configuration writes
    input  wire logic                         cfg_valid,
    output logic                              cfg_ready,
    input  wire logic [uer_pkg::IDX_W-1:0]    cfg_index,
    input  wire logic [uer_pkg::CFG_W-1:0]    cfg_data
);
    import uer_pkg::*;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_TRIG,
        PH_WAIT,
        PH_TIME,
        PH_DONE
    } phase_t;

    phase_t                phase_reg, phase_next;
    logic [CFG_W-1:0]      trig_cnt_reg, trig_cnt_next;
    logic [COUNT_BITS-1:0] pulse_reg, pulse_next;
    logic                  last_echo_reg;
    logic [CFG_W-1:0]      ticks_per_cm_reg;
    logic [CFG_W-1:0]      trigger_ticks_reg;

    // output register
    logic              m_valid_reg, m_valid_next;
    logic              trig_reg, trig_next;
    logic              busy_res_reg, busy_res_next;
    logic              ready_res_reg, ready_res_next;
    logic              res_valid_reg, res_valid_next;
    logic [DIST_W-1:0] dist_reg, dist_next;

    logic              accept;
    logic              rise;
    logic              div_start;
    logic              div_busy;
    logic [DIST_W-1:0] div_quotient;

    uer_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (pulse_reg),
        .divisor  (ticks_per_cm_reg),
        .busy     (div_busy),
        .quotient (div_quotient)
    );

    // Take a tick when the divider is free and the output slot frees up
    assign s_ready   = !div_busy && (!m_valid_reg || m_ready);
    assign accept    = s_valid && s_ready;
    assign rise      = s_echo && !last_echo_reg;
    assign cfg_ready = 1'b1;

    always_comb begin
        phase_next     = phase_reg;
        trig_cnt_next  = trig_cnt_reg;
        pulse_next     = pulse_reg;
        div_start      = 1'b0;
        trig_next      = 1'b0;
        res_valid_next = 1'b0;
        dist_next      = '0;

        unique case (phase_reg)
            PH_TRIG: begin
                trig_next = 1'b1;
                trig_cnt_next = (trig_cnt_reg < TRIG_MAX) ? trig_cnt_reg + CFG_W'(1)
                                                          : trig_cnt_reg;
                if (trig_cnt_next >= trigger_ticks_reg) begin
                    phase_next = PH_WAIT;
                end
            end
            PH_WAIT: begin
                // echo already high at trigger end: hold for the next rising edge
                if (rise) begin
                    pulse_next = COUNT_BITS'(1);
                    phase_next = PH_TIME;
                end
            end
            PH_TIME: begin
                if (s_echo) begin
                    if (pulse_reg < COUNT_MAX) begin
                        pulse_next = pulse_reg + COUNT_BITS'(1);
                    end
                end else begin
                    // falling edge: launch the divider, distance lands in its result
                    div_start  = accept;
                    phase_next = PH_DONE;
                end
            end
            PH_DONE: begin
                if (s_command == CMD_TAKE) begin
                    res_valid_next = 1'b1;
                    dist_next      = div_quotient;
                    phase_next     = PH_IDLE;
                end
            end
            default: begin
                // idle, and any stray phase code behaves as idle
                phase_next = PH_IDLE;
                if (s_command == CMD_START) begin
                    trig_next     = 1'b1;
                    trig_cnt_next = CFG_W'(1);
                    phase_next    = (CFG_W'(1) >= trigger_ticks_reg) ? PH_WAIT : PH_TRIG;
                end
            end
        endcase

        busy_res_next  = (phase_next == PH_TRIG) || (phase_next == PH_WAIT) ||
                         (phase_next == PH_TIME);
        ready_res_next = (phase_next == PH_DONE);

        if (accept) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg         <= PH_IDLE;
            trig_cnt_reg      <= '0;
            pulse_reg         <= '0;
            last_echo_reg     <= 1'b0;
            m_valid_reg       <= 1'b0;
            ticks_per_cm_reg  <= TICKS_PER_CM_RESET;
            trigger_ticks_reg <= TRIGGER_TICKS_RESET;
        end else begin
            m_valid_reg <= m_valid_next;
            if (accept) begin
                phase_reg     <= phase_next;
                trig_cnt_reg  <= trig_cnt_next;
                pulse_reg     <= pulse_next;
                last_echo_reg <= s_echo;
            end
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    CFG_TICKS_PER_CM:  ticks_per_cm_reg  <= cfg_data;
                    CFG_TRIGGER_TICKS: trigger_ticks_reg <= cfg_data;
                    default: ;
                endcase
            end
        end
        // payload: load with each accepted tick, hold while stalled
        if (accept) begin
            trig_reg      <= trig_next;
            busy_res_reg  <= busy_res_next;
            ready_res_reg <= ready_res_next;
            res_valid_reg <= res_valid_next;
            dist_reg      <= dist_next;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_trigger_out  = trig_reg;
    assign m_busy_res     = busy_res_reg;
    assign m_ready_res    = ready_res_reg;
    assign m_result_valid = res_valid_reg;
    assign m_distance_cm  = dist_reg;

endmodule
`default_nettype wire

// ===== src/uer_checker.sv =====
`default_nettype none
module uer_checker (
    input wire logic                      aclk,
    input wire logic                      aresetn,
    input wire logic                      m_valid,
    input wire logic                      m_ready,
    input wire logic                      m_trigger_out,
    input wire logic                      m_busy_res,
    input wire logic                      m_ready_res,
    input wire logic                      m_result_valid,
    input wire logic [uer_pkg::DIST_W-1:0] m_distance_cm
);

    // Stalled result word holds its distance
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_distance_cm))
        else $error("result word changed while stalled");

    // Busy and ready never both set
    a_busy_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_busy_res && m_ready_res))
        else $error("busy and ready flags both set");

    // A take returns the block to idle
    a_take_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_result_valid |-> !m_busy_res && !m_ready_res && !m_trigger_out)
        else $error("take did not leave the block idle");

    // Distance is zero unless a take returned it
    a_dist_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_result_valid |-> m_distance_cm == '0)
        else $error("distance shown without a take");

    // Trigger only drives during a busy measurement
    a_trig_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_trigger_out |-> m_busy_res)
        else $error("trigger high while not busy");

endmodule

bind ultrasonic_echo_ranger uer_checker u_uer_checker (.*);
`default_nettype wire

// ===== dv/tb_ultrasonic_echo_ranger.sv =====
`default_nettype none
module tb_ultrasonic_echo_ranger;
    timeunit 1ns;
    timeprecision 1ps;

    import uer_pkg::*;

    // Command code with no meaning of its own; the block must take it as a plain tick
    localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;

    // Cycles to let pass after the last result word so a running divide can finish
    localparam int SETTLE_CYCLES = COUNT_BITS + 8;

    typedef enum logic [2:0] {
        RG_IDLE,
        RG_TRIGGER,
        RG_AWAIT,
        RG_TIMING,
        RG_HOLD
    } ranger_phase_t;

    // One timer tick as it goes into the block
    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             echo;
    } tick_t;

    // One result word as it should come out
    typedef struct packed {
        logic              trig;
        logic              busy;
        logic              done;
        logic              taken;
        logic [DIST_W-1:0] cm;
    } range_word_t;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_valid   = 1'b0;
    logic                 s_ready;
    logic [CMD_W-1:0]     s_command = CMD_NONE;
    logic                 s_echo    = 1'b0;
    logic                 m_valid;
    logic                 m_ready   = 1'b0;
    logic                 m_trigger_out;
    logic                 m_busy_res;
    logic                 m_ready_res;
    logic                 m_result_valid;
    logic [DIST_W-1:0]    m_distance_cm;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [IDX_W-1:0]     cfg_index = CFG_TICKS_PER_CM;
    logic [CFG_W-1:0]     cfg_data  = '0;

    ultrasonic_echo_ranger dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_command      (s_command),
        .s_echo         (s_echo),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_trigger_out  (m_trigger_out),
        .m_busy_res     (m_busy_res),
        .m_ready_res    (m_ready_res),
        .m_result_valid (m_result_valid),
        .m_distance_cm  (m_distance_cm),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Shadow copy of the ranger: registers and measurement state
    logic [CFG_W-1:0]      rg_cm_div     = TICKS_PER_CM_RESET;
    logic [CFG_W-1:0]      rg_trig_len   = TRIGGER_TICKS_RESET;
    ranger_phase_t         rg_phase      = RG_IDLE;
    logic [CFG_W-1:0]      rg_trig_count = '0;
    logic [COUNT_BITS-1:0] rg_width      = '0;
    logic                  rg_last_echo  = 1'b0;
    logic [DIST_W-1:0]     rg_held       = '0;

    tick_t       pending_ticks[$];   // words waiting for the driver
    range_word_t due_words[$];       // result words predicted, not yet seen
    int          ticks_in_flight = 0;  // queued or on the bus, not yet accepted
    int          ticks_queued    = 0;
    int          fault_count     = 0;
    int          tx_idle_pct     = 0;
    int          rx_idle_pct     = 0;

    // Convert echo width to centimeters; zero divisor and large quotients clamp to 255
    function automatic logic [DIST_W-1:0] width_to_cm(logic [COUNT_BITS-1:0] w,
                                                      logic [CFG_W-1:0] d);
        logic [COUNT_BITS-1:0] q;
        if (d == '0)
            return DIST_MAX;
        q = w / d;
        return (q > COUNT_BITS'(DIST_MAX)) ? DIST_MAX : q[DIST_W-1:0];
    endfunction

    // Advance the shadow ranger by one tick and return the word it shows afterwards
    function automatic range_word_t advance_ranger(tick_t t);
        range_word_t w;
        logic        rise;
        w    = '0;
        rise = t.echo && !rg_last_echo;
        case (rg_phase)
            RG_IDLE: begin
                // start from idle is the first trigger tick; a zero length acts as one
                if (t.cmd == CMD_START) begin
                    w.trig        = 1'b1;
                    rg_trig_count = 16'd1;
                    rg_phase      = (rg_trig_count >= rg_trig_len) ? RG_AWAIT : RG_TRIGGER;
                end
            end
            RG_TRIGGER: begin
                w.trig = 1'b1;
                if (rg_trig_count != TRIG_MAX)
                    rg_trig_count = rg_trig_count + 1'b1;
                if (rg_trig_count >= rg_trig_len)
                    rg_phase = RG_AWAIT;
            end
            RG_AWAIT: begin
                // only a fresh rising edge opens the window; echo already high waits
                if (rise) begin
                    rg_width = COUNT_BITS'(1);
                    rg_phase = RG_TIMING;
                end
            end
            RG_TIMING: begin
                if (t.echo) begin
                    if (rg_width != COUNT_MAX)
                        rg_width = rg_width + 1'b1;
                end else begin
                    rg_held  = width_to_cm(rg_width, rg_cm_div);
                    rg_phase = RG_HOLD;
                end
            end
            RG_HOLD: begin
                // starts are dropped here; only a take frees the block
                if (t.cmd == CMD_TAKE) begin
                    w.taken  = 1'b1;
                    w.cm     = rg_held;
                    rg_phase = RG_IDLE;
                end
            end
            default: rg_phase = RG_IDLE;
        endcase
        rg_last_echo = t.echo;
        w.busy = (rg_phase == RG_TRIGGER) || (rg_phase == RG_AWAIT) || (rg_phase == RG_TIMING);
        w.done = (rg_phase == RG_HOLD);
        return w;
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fault_count++;
        end
    endfunction

    function automatic void push_tick(logic [CMD_W-1:0] cmd, logic echo);
        tick_t t;
        t.cmd  = cmd;
        t.echo = echo;
        pending_ticks.push_back(t);
        ticks_in_flight++;
        ticks_queued++;
    endfunction

    // Mostly plain ticks, now and then any code, spare one included
    function automatic logic [CMD_W-1:0] filler_cmd();
        if ($urandom_range(99) < 85)
            return CMD_NONE;
        return CMD_W'($urandom_range(3));
    endfunction

    // Driver: predict each accepted word, then offer the next one or idle
    always @(posedge aclk) begin
        tick_t seen;
        tick_t nxt;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                seen.cmd  = s_command;
                seen.echo = s_echo;
                due_words.push_back(advance_ranger(seen));
                ticks_in_flight--;
            end
            // hold the payload while an offered word is still waiting
            if (!s_valid || s_ready) begin
                if (pending_ticks.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
                    nxt = pending_ticks.pop_front();
                    s_valid   <= 1'b1;
                    s_command <= nxt.cmd;
                    s_echo    <= nxt.echo;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: compare every result word against the oldest prediction
    always @(posedge aclk) begin
        range_word_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (due_words.size() == 0) begin
                    $error("result word arrived with no prediction pending");
                    fault_count++;
                end else begin
                    want = due_words.pop_front();
                    check_field("trigger_out", 32'(want.trig), 32'(m_trigger_out));
                    check_field("busy_res", 32'(want.busy), 32'(m_busy_res));
                    check_field("ready_res", 32'(want.done), 32'(m_ready_res));
                    check_field("result_valid", 32'(want.taken), 32'(m_result_valid));
                    check_field("distance_cm", 32'(want.cm), 32'(m_distance_cm));
                end
            end
            m_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Hold off until every word is accepted and answered, then let the divider finish
    task automatic wait_quiet();
        while (ticks_in_flight != 0 || due_words.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Steer the block back to idle with whatever ticks its current phase needs
    task automatic park_idle();
        wait_quiet();
        while (rg_phase != RG_IDLE) begin
            case (rg_phase)
                RG_TRIGGER: repeat (int'(rg_trig_len) - int'(rg_trig_count))
                                push_tick(CMD_NONE, 1'b0);
                RG_AWAIT: begin
                    push_tick(CMD_NONE, 1'b0);
                    push_tick(CMD_NONE, 1'b1);
                end
                RG_TIMING: push_tick(CMD_NONE, 1'b0);
                default:   push_tick(CMD_TAKE, 1'b0);
            endcase
            wait_quiet();
        end
    endtask

    // Write one register; only called with the block parked
    task automatic write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CFG_TICKS_PER_CM)
            rg_cm_div = val;
        else
            rg_trig_len = val;
    endtask

    // Mostly complete measurements with random timing, the rest loose noise
    task automatic play_random(int budget, int trig_len);
        int stop_at;
        int w;
        stop_at = ticks_queued + budget;
        while (ticks_queued < stop_at) begin
            if ($urandom_range(99) < 80) begin
                push_tick(CMD_START, 1'($urandom_range(1)));
                repeat ((trig_len > 0 ? trig_len - 1 : 0) + $urandom_range(2))
                    push_tick(filler_cmd(), 1'b0);
                repeat ($urandom_range(6)) push_tick(filler_cmd(), 1'b0);
                // keep pulses short; a few long ones can push the distance to its clamp
                w = ($urandom_range(9) == 0) ? $urandom_range(400, 1) : $urandom_range(40, 1);
                repeat (w) push_tick(filler_cmd(), 1'b1);
                push_tick(filler_cmd(), 1'b0);
                repeat ($urandom_range(3)) push_tick(filler_cmd(), 1'($urandom_range(1)));
                push_tick(CMD_TAKE, 1'($urandom_range(1)));
            end else begin
                repeat ($urandom_range(8, 1))
                    push_tick(CMD_W'($urandom_range(3)), 1'($urandom_range(1)));
            end
        end
    endtask

    initial begin
        int div_set[3];
        int trig_set[3];
        div_set  = '{1, 7, 3};
        trig_set = '{1, 2, 5};

        tx_idle_pct = 19;
        rx_idle_pct = 47;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed, reset register values: spare code, take with nothing ready,
        // echo edges while idle
        push_tick(CMD_SPARE, 1'b0);
        push_tick(CMD_TAKE, 1'b0);
        push_tick(CMD_NONE, 1'b1);
        push_tick(CMD_NONE, 1'b0);
        // echo already high as the trigger ends: wait for the next rising edge
        push_tick(CMD_START, 1'b0);
        repeat (8) push_tick(CMD_NONE, 1'b0);
        push_tick(CMD_NONE, 1'b1);
        repeat (3) push_tick(CMD_NONE, 1'b1);
        push_tick(CMD_START, 1'b1);           // start while busy: dropped
        push_tick(CMD_NONE, 1'b0);
        repeat (116) push_tick(CMD_NONE, 1'b1);
        push_tick(CMD_NONE, 1'b0);            // falling edge: 116 / 58 = 2 cm
        push_tick(CMD_START, 1'b0);           // start with a result unclaimed: dropped
        push_tick(CMD_TAKE, 1'b0);
        push_tick(CMD_TAKE, 1'b0);            // nothing left to take
        park_idle();

        // Zero divisor clamps to 255; zero trigger length acts as one tick
        write_reg(CFG_TICKS_PER_CM, '0);
        write_reg(CFG_TRIGGER_TICKS, '0);
        push_tick(CMD_START, 1'b0);
        repeat (2) push_tick(CMD_NONE, 1'b0);
        repeat (3) push_tick(CMD_NONE, 1'b1);
        push_tick(CMD_NONE, 1'b0);
        push_tick(CMD_TAKE, 1'b0);
        park_idle();

        // Largest divisor and a long trigger
        write_reg(CFG_TICKS_PER_CM, TRIG_MAX);
        write_reg(CFG_TRIGGER_TICKS, 16'd40);
        push_tick(CMD_START, 1'b0);
        repeat (39) push_tick(CMD_NONE, 1'b0);
        repeat (10) push_tick(CMD_NONE, 1'b1);
        push_tick(CMD_NONE, 1'b0);
        push_tick(CMD_TAKE, 1'b0);

        // Random phases: sender light and receiver heavy, then swapped, then no idling
        for (int p = 0; p < 3; p++) begin
            park_idle();
            write_reg(CFG_TICKS_PER_CM, CFG_W'(div_set[p]));
            write_reg(CFG_TRIGGER_TICKS, CFG_W'(trig_set[p]));
            if (p == 1) begin
                tx_idle_pct = 47;
                rx_idle_pct = 19;
            end else if (p == 2) begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            play_random(560, trig_set[p]);
        end
        wait_quiet();

        if (fault_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run
    initial begin
        #2_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule
`default_nettype wire
